// ===== rtl/core/url_percent_codec_defines.svh =====
`ifndef URL_PERCENT_CODEC_DEFINES_SVH
`define URL_PERCENT_CODEC_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define UPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/upc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package upc_pkg;

    localparam int MAX_RESULTS = 3;

    localparam logic [2:0] MODE_PATH     = 3'd0;
    localparam logic [2:0] MODE_SEGMENT  = 3'd1;
    localparam logic [2:0] MODE_HOST     = 3'd2;
    localparam logic [2:0] MODE_ZONE     = 3'd3;
    localparam logic [2:0] MODE_USERINFO = 3'd4;
    localparam logic [2:0] MODE_QUERY    = 3'd5;
    localparam logic [2:0] MODE_FRAGMENT = 3'd6;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_MODE      = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
        logic       bad_escape;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic logic must_escape(input logic [7:0] c, input logic [2:0] mode);
        logic host_like;
        logic esc;
        host_like = (mode == MODE_HOST) || (mode == MODE_ZONE);
        esc = 1'b1;
        if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            esc = 1'b0;
        end else if (host_like && (c inside {"!", "$", "&", "(", ")", "'", "*", "+",
                                             ",", ";", "=", ":", "[", "]", "<", ">",
                                             "\""})) begin
            esc = 1'b0;
        end else if (c inside {"-", ".", "_", "~"}) begin
            esc = 1'b0;
        end else if (c inside {"&", ",", ";", "?", "@", "$", "+", "=", ":", "/"}) begin
            case (mode)
                MODE_PATH:     esc = (c == "?");
                MODE_SEGMENT:  esc = c inside {"/", ";", ",", "?"};
                MODE_USERINFO: esc = c inside {"@", "/", "?", ":"};
                MODE_QUERY:    esc = 1'b1;
                MODE_FRAGMENT: esc = 1'b0;
                default:       esc = 1'b1;
            endcase
        end else if ((mode == MODE_FRAGMENT) && (c inside {"!", "(", ")", "*"})) begin
            esc = 1'b0;
        end
        return esc;
    endfunction

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = {4'h0, nib} + 8'h30;
        end else begin
            d = {4'h0, nib} + 8'h37;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/url_percent_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------------------
// s_        | in        | s_valid / s_ready    | s_in_byte, s_in_last
// m_        | out       | m_valid / m_ready    | m_out_byte, m_has_byte, m_out_last,
//           |           |                      | m_bad_escape
// apb       | in        | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// one input beat is decoded in the cycle it is accepted and its results land in a
// three-slot result register; the slots drain one beat per cycle on m_ while m_ready is high
// decode and plain encode bytes give at most one result, so a beat per cycle sustains while m_ready is high
// an escaped encode byte gives three results and holds s_ready low while more than one of them remains
// s_ready is high when the result register is empty or its last slot leaves this cycle
// aresetn is synchronous active low; it clears config, string state and the slot count

`include "url_percent_codec_defines.svh"

module url_percent_codec (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_in_last,
    // result stream
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_out_byte,
    output logic             m_has_byte,
    output logic             m_out_last,
    output logic             m_bad_escape
);

    // config registers
    logic        direction_reg;
    logic [2:0]  mode_reg;
    logic        cfg_wr;

    // per-string state
    upc_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic        error_seen_reg, error_seen_next;

    // result slots, slot 0 faces m_
    upc_pkg::res_t res_reg [upc_pkg::MAX_RESULTS];
    upc_pkg::res_t res_next [upc_pkg::MAX_RESULTS];
    logic [1:0]  cnt_reg, cnt_next;

    logic        s_acc;
    logic        m_acc;

    // decode classification of the incoming byte
    upc_pkg::hex_t hex;
    logic        dec_err;
    logic        dec_emit;
    logic [7:0]  dec_val;
    logic [7:0]  esc_val;
    logic        is25;
    logic        enc_esc;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= upc_pkg::DIR_ENCODE;
            mode_reg      <= upc_pkg::MODE_PATH;
        end else if (cfg_wr) begin
            case (paddr[2])
                upc_pkg::REG_DIRECTION: direction_reg <= pwdata[0];
                upc_pkg::REG_MODE:      mode_reg      <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            upc_pkg::REG_DIRECTION: prdata = {31'd0, direction_reg};
            upc_pkg::REG_MODE:      prdata = {29'd0, mode_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- handshakes
    // take a new beat only when every slot will be free after this edge
    assign s_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_acc   = m_valid && m_ready;

    // ---------------------------------------------------------------- classification
    assign hex     = upc_pkg::hex_value(s_in_byte);
    assign esc_val = {nibble_reg, hex.value};
    assign is25    = (nibble_reg == 4'h2) && (hex.value == 4'h5);
    assign enc_esc = upc_pkg::must_escape(s_in_byte, mode_reg);

    always_comb begin
        dec_err  = 1'b0;
        dec_emit = 1'b0;
        dec_val  = s_in_byte;
        case (phase_reg)
            upc_pkg::PH_HIGH: begin
                // a first digit on the final byte truncates the escape
                dec_err = !hex.valid || s_in_last;
            end
            upc_pkg::PH_LOW: begin
                dec_val = esc_val;
                if (!hex.valid) begin
                    dec_err = 1'b1;
                end else if ((mode_reg == upc_pkg::MODE_HOST) && !nibble_reg[3] && !is25) begin
                    dec_err = 1'b1;
                end else if ((mode_reg == upc_pkg::MODE_ZONE) && !is25 && (esc_val != " ")
                             && upc_pkg::must_escape(esc_val, upc_pkg::MODE_HOST)) begin
                    dec_err = 1'b1;
                end else begin
                    dec_emit = 1'b1;
                end
            end
            default: begin
                if (s_in_byte == "%") begin
                    dec_err = s_in_last;
                end else if (s_in_byte == "+") begin
                    dec_val  = (mode_reg == upc_pkg::MODE_QUERY) ? 8'(" ") : 8'("+");
                    dec_emit = 1'b1;
                end else if (((mode_reg == upc_pkg::MODE_HOST) ||
                              (mode_reg == upc_pkg::MODE_ZONE)) &&
                             !s_in_byte[7] && enc_esc) begin
                    // host and zone forbid plain ascii bytes their class would escape
                    dec_err = 1'b1;
                end else begin
                    dec_emit = 1'b1;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------- next string state
    always_comb begin
        phase_next      = phase_reg;
        nibble_next     = nibble_reg;
        error_seen_next = error_seen_reg;
        if (s_acc) begin
            if (s_in_last) begin
                // end of string wipes everything
                phase_next      = upc_pkg::PH_IDLE;
                nibble_next     = 4'h0;
                error_seen_next = 1'b0;
            end else if (error_seen_reg || (direction_reg == upc_pkg::DIR_ENCODE)) begin
                // dropping bytes, or encoding with any pending escape left alone
            end else begin
                case (phase_reg)
                    upc_pkg::PH_HIGH: begin
                        if (hex.valid) begin
                            nibble_next = hex.value;
                            phase_next  = upc_pkg::PH_LOW;
                        end
                    end
                    upc_pkg::PH_LOW: begin
                        if (hex.valid) begin
                            phase_next = upc_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = (s_in_byte == "%") ? upc_pkg::PH_HIGH : upc_pkg::PH_IDLE;
                    end
                endcase
                if (dec_err) begin
                    error_seen_next = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- results of this beat
    always_comb begin
        for (int i = 0; i < upc_pkg::MAX_RESULTS; i++) begin
            res_next[i] = '0;
        end
        cnt_next = 2'd0;
        if (error_seen_reg) begin
            if (s_in_last) begin
                res_next[0] = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1,
                                bad_escape: 1'b1};
                cnt_next    = 2'd1;
            end
        end else if (direction_reg == upc_pkg::DIR_ENCODE) begin
            if ((mode_reg == upc_pkg::MODE_QUERY) && (s_in_byte == " ")) begin
                res_next[0] = '{out_byte: 8'("+"), has_byte: 1'b1, out_last: s_in_last,
                                bad_escape: 1'b0};
                cnt_next    = 2'd1;
            end else if (enc_esc) begin
                res_next[0] = '{out_byte: 8'("%"), has_byte: 1'b1, out_last: 1'b0,
                                bad_escape: 1'b0};
                res_next[1] = '{out_byte: upc_pkg::hex_digit(s_in_byte[7:4]), has_byte: 1'b1,
                                out_last: 1'b0, bad_escape: 1'b0};
                res_next[2] = '{out_byte: upc_pkg::hex_digit(s_in_byte[3:0]), has_byte: 1'b1,
                                out_last: s_in_last, bad_escape: 1'b0};
                cnt_next    = 2'd3;
            end else begin
                res_next[0] = '{out_byte: s_in_byte, has_byte: 1'b1, out_last: s_in_last,
                                bad_escape: 1'b0};
                cnt_next    = 2'd1;
            end
        end else if (dec_err) begin
            res_next[0] = '{out_byte: 8'h00, has_byte: 1'b0, out_last: s_in_last,
                            bad_escape: 1'b1};
            cnt_next    = 2'd1;
        end else if (dec_emit) begin
            res_next[0] = '{out_byte: dec_val, has_byte: 1'b1, out_last: s_in_last,
                            bad_escape: 1'b0};
            cnt_next    = 2'd1;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= upc_pkg::PH_IDLE;
            nibble_reg     <= 4'h0;
            error_seen_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end else begin
            phase_reg      <= phase_next;
            nibble_reg     <= nibble_next;
            error_seen_reg <= error_seen_next;
            if (s_acc) begin
                cnt_reg <= cnt_next;
            end else if (m_acc) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // slot payload, shifts toward slot 0 as beats leave
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < upc_pkg::MAX_RESULTS; i++) begin
                res_reg[i] <= res_next[i];
            end
        end else if (m_acc) begin
            for (int i = 0; i < upc_pkg::MAX_RESULTS - 1; i++) begin
                res_reg[i] <= res_reg[i + 1];
            end
        end
    end

    assign m_out_byte   = res_reg[0].out_byte;
    assign m_has_byte   = res_reg[0].has_byte;
    assign m_out_last   = res_reg[0].out_last;
    assign m_bad_escape = res_reg[0].bad_escape;

    // ---------------------------------------------------------------- checks
    `UPC_ASSERT_IMPLY(a_no_accept_busy, aclk, aresetn, cnt_reg > 2'd1, !s_ready, "accept while slots busy")
    `UPC_ASSERT_IMPLY(a_err_no_byte, aclk, aresetn, m_valid && m_bad_escape, !m_has_byte, "error beat carries a byte")
    `UPC_ASSERT_NEXT(a_last_clears, aclk, aresetn, s_acc && s_in_last, (phase_reg == upc_pkg::PH_IDLE) && !error_seen_reg, "string state kept past last")
    `UPC_ASSERT_NEXT(a_drop_silent, aclk, aresetn, s_acc && error_seen_reg && !s_in_last, cnt_reg == 2'd0, "dropped byte gave a result")

endmodule

`default_nettype wire

// ===== bench/upc_checker.sv =====
`timescale 1ns / 1ps

module upc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_has_byte,
    input  logic        m_out_last,
    input  logic        m_bad_escape,
    output int          failures,
    output int          outstanding
);
    import upc_pkg::*;

    // shadow registers and per-string state
    logic       codec_dir;
    logic [2:0] codec_mode;
    phase_t     esc_phase;
    logic [3:0] esc_high;
    logic       drop_rest;
    res_t       codec_results[$];
    int         fail_count = 0;

    assign failures = fail_count;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic escape_needed(input logic [7:0] c, input logic [2:0] m);
        logic hostish;
        hostish = (m == MODE_HOST) || (m == MODE_ZONE);
        if (is_alnum(c))
            return 1'b0;
        if (hostish) begin
            case (c)
                "!", "$", "&", "(", ")", "'", "*", "+", ",", ";", "=", ":",
                "[", "]", "<", ">", "\"": return 1'b0;
                default: ;
            endcase
        end
        case (c)
            "-", ".", "_", "~": return 1'b0;
            "&", ",", ";", "?", "@", "$", "+", "=", ":", "/": begin
                case (m)
                    MODE_PATH:     return c == "?";
                    MODE_SEGMENT:  return c == "/" || c == ";" || c == "," || c == "?";
                    MODE_USERINFO: return c == "@" || c == "/" || c == "?" || c == ":";
                    MODE_QUERY:    return 1'b1;
                    MODE_FRAGMENT: return 1'b0;
                    default:       return 1'b1;
                endcase
            end
            "!", "(", ")", "*": return m != MODE_FRAGMENT;
            default: return 1'b1;
        endcase
    endfunction

    function automatic int hex_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + nib;
        return "A" + nib - 8'd10;
    endfunction

    function automatic void expect_beat(input logic [7:0] b, input logic has,
                                        input logic last, input logic bad);
        res_t r;
        r.out_byte   = b;
        r.has_byte   = has;
        r.out_last   = last;
        r.bad_escape = bad;
        codec_results.insert(codec_results.size(), r);
    endfunction

    function automatic void clear_string();
        esc_phase = PH_IDLE;
        esc_high  = 4'h0;
        drop_rest = 1'b0;
    endfunction

    function automatic void predict_codec(input logic [7:0] c, input logic last);
        int         d;
        logic       fault;
        logic       produce;
        logic [7:0] val;
        fault   = 1'b0;
        produce = 1'b0;
        val     = 8'h00;
        d       = hex_of(c);
        if (drop_rest) begin
            if (last) begin
                expect_beat(8'h00, 1'b0, 1'b1, 1'b1);
                clear_string();
            end
            return;
        end
        if (codec_dir == DIR_ENCODE) begin
            if (codec_mode == MODE_QUERY && c == " ") begin
                expect_beat("+", 1'b1, last, 1'b0);
            end else if (escape_needed(c, codec_mode)) begin
                expect_beat("%", 1'b1, 1'b0, 1'b0);
                expect_beat(hex_char(c[7:4]), 1'b1, 1'b0, 1'b0);
                expect_beat(hex_char(c[3:0]), 1'b1, last, 1'b0);
            end else begin
                expect_beat(c, 1'b1, last, 1'b0);
            end
            if (last)
                clear_string();
            return;
        end
        case (esc_phase)
            PH_HIGH: begin
                if (d < 0 || last) begin
                    fault = 1'b1;
                end else begin
                    esc_high  = d[3:0];
                    esc_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (d < 0) begin
                    fault = 1'b1;
                end else begin
                    val = {esc_high, d[3:0]};
                    if (codec_mode == MODE_HOST && esc_high < 4'd8 && val != 8'h25)
                        fault = 1'b1;
                    else if (codec_mode == MODE_ZONE && val != 8'h25 && val != " " &&
                             escape_needed(val, MODE_HOST))
                        fault = 1'b1;
                    else
                        produce = 1'b1;
                    esc_phase = PH_IDLE;
                end
            end
            default: begin
                esc_phase = PH_IDLE;
                if (c == "%") begin
                    esc_phase = PH_HIGH;
                    if (last)
                        fault = 1'b1;
                end else if (c == "+") begin
                    val     = (codec_mode == MODE_QUERY) ? " " : "+";
                    produce = 1'b1;
                end else if ((codec_mode == MODE_HOST || codec_mode == MODE_ZONE) && !c[7] &&
                             escape_needed(c, codec_mode)) begin
                    fault = 1'b1;
                end else begin
                    val     = c;
                    produce = 1'b1;
                end
            end
        endcase
        if (fault) begin
            expect_beat(8'h00, 1'b0, last, 1'b1);
            if (last)
                clear_string();
            else
                drop_rest = 1'b1;
        end else begin
            if (last)
                clear_string();
            if (produce)
                expect_beat(val, 1'b1, last, 1'b0);
        end
    endfunction

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        logic wrong;
        if (!aresetn) begin
            codec_dir  = DIR_ENCODE;
            codec_mode = MODE_PATH;
            clear_string();
            codec_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_DIRECTION: codec_dir  = pwdata[0];
                    REG_MODE:      codec_mode = pwdata[2:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_codec(s_in_byte, s_in_last);
            if (m_valid && m_ready) begin
                got.out_byte   = m_out_byte;
                got.has_byte   = m_has_byte;
                got.out_last   = m_out_last;
                got.bad_escape = m_bad_escape;
                if (codec_results.size() == 0) begin
                    $display("%0t: unexpected beat, expected none got byte %02h has %b last %b bad %b",
                             $time, got.out_byte, got.has_byte, got.out_last, got.bad_escape);
                    fail_count++;
                end else begin
                    want  = codec_results.pop_front();
                    wrong = 1'b0;
                    if (got.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.out_byte, got.out_byte);
                        wrong = 1'b1;
                    end
                    if (got.has_byte !== want.has_byte) begin
                        $display("%0t: has_byte expected %b got %b",
                                 $time, want.has_byte, got.has_byte);
                        wrong = 1'b1;
                    end
                    if (got.out_last !== want.out_last) begin
                        $display("%0t: out_last expected %b got %b",
                                 $time, want.out_last, got.out_last);
                        wrong = 1'b1;
                    end
                    if (got.bad_escape !== want.bad_escape) begin
                        $display("%0t: bad_escape expected %b got %b",
                                 $time, want.bad_escape, got.bad_escape);
                        wrong = 1'b1;
                    end
                    if (wrong)
                        fail_count++;
                end
            end
        end
        outstanding <= codec_results.size();
    end

endmodule

// ===== bench/tb_url_percent_codec.sv =====
`timescale 1ns / 1ps

module tb_url_percent_codec;
    import upc_pkg::*;

    // the eighth mode value is not named in the package but the register takes it
    localparam logic [2:0] MODE_SPARE = 3'd7;
    localparam int PHASE_BEATS        = 28;
    localparam int LONG_STALL_CYCLES  = 300;
    localparam int DRAIN_CYCLES       = 6;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        s_in_last = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_has_byte;
    logic        m_out_last;
    logic        m_bad_escape;

    int failures;
    int outstanding;
    int beats_sent  = 0;
    // bumped by the stimulus, served by the receiver process
    int stall_asked = 0;
    // no idling on either side while set
    bit steady      = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    url_percent_codec i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_has_byte   (m_has_byte),
        .m_out_last   (m_out_last),
        .m_bad_escape (m_bad_escape)
    );

    upc_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_has_byte   (m_has_byte),
        .m_out_last   (m_out_last),
        .m_bad_escape (m_bad_escape),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    // one input beat; valid stays up across back-to-back beats
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_text(input string txt, input bit close);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], close && (i == txt.len() - 1));
    endtask

    // drop valid and hold off until every expected beat is back, then let the
    // block settle in case the last beat produced nothing
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // setup cycle then access cycle; the register lands on the access edge
    task automatic apb_write(input logic reg_sel, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_codec(input logic dir, input logic [2:0] mode);
        wait_drained();
        apb_write(REG_DIRECTION, {31'd0, dir});
        apb_write(REG_MODE, {29'd0, mode});
    endtask

    // mostly letters and digits, then url punctuation, then high and arbitrary bytes
    function automatic logic [7:0] pick_plain();
        string alnum;
        string marks;
        int    r;
        alnum = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        marks = "-._~!$&()'*+,;=:@/?#[] <>\"%";
        r = $urandom_range(0, 99);
        if (r < 55)
            return alnum[$urandom_range(0, alnum.len() - 1)];
        if (r < 80)
            return marks[$urandom_range(0, marks.len() - 1)];
        if (r < 90)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    // hex digit text in either case
    function automatic logic [7:0] hex_text(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + nib;
        return ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
    endfunction

    // escape values biased toward the ones host and zone modes accept
    function automatic logic [7:0] pick_escape_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(0, 255));
        if (r < 70)
            return 8'($urandom_range(128, 255));
        if (r < 85)
            return 8'h25;
        return 8'h20;
    endfunction

    // decode strings are mostly well formed: plain bytes, escapes and plus signs,
    // with some raw noise and an occasional escape cut off at the end
    task automatic send_random_string(input logic dir);
        logic [7:0] text[$];
        logic [7:0] v;
        int         len;
        int         r;
        len = $urandom_range(1, 10);
        while (text.size() < len) begin
            r = $urandom_range(0, 99);
            if (dir == DIR_ENCODE || r < 60) begin
                text.insert(text.size(), pick_plain());
            end else if (r < 80) begin
                v = pick_escape_value();
                text.insert(text.size(), "%");
                text.insert(text.size(), hex_text(v[7:4]));
                text.insert(text.size(), hex_text(v[3:0]));
            end else if (r < 90) begin
                text.insert(text.size(), "+");
            end else begin
                text.insert(text.size(), 8'($urandom_range(0, 255)));
            end
        end
        if (dir == DIR_DECODE && $urandom_range(0, 9) == 0) begin
            text.insert(text.size(), "%");
            r = $urandom_range(0, 2);
            if (r == 1)
                text.insert(text.size(), hex_text(4'($urandom_range(0, 15))));
            else if (r == 2)
                text.insert(text.size(), "g");
        end
        foreach (text[i])
            send_beat(text[i], i == text.size() - 1);
    endtask

    // stimulus
    initial begin
        int         phase_start;
        logic       dir;
        logic [2:0] mode;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // query space becomes plus, byte extremes are escaped
        set_codec(DIR_ENCODE, MODE_QUERY);
        send_text(" ", 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        // spare mode escapes the reserved set
        set_codec(DIR_ENCODE, MODE_SPARE);
        send_text("+", 1'b1);
        // host escape below 80, then the rest of the string is dropped
        set_codec(DIR_DECODE, MODE_HOST);
        send_text("%41x", 1'b1);
        // zone escape of a high byte
        set_codec(DIR_DECODE, MODE_ZONE);
        send_text("%80", 1'b1);
        // host plain byte that the class escapes
        set_codec(DIR_DECODE, MODE_HOST);
        send_text("/", 1'b1);
        // truncated escapes, both depths, and a clean decode in mixed case
        set_codec(DIR_DECODE, MODE_QUERY);
        send_text("a%4", 1'b1);
        send_text("+%fF", 1'b1);
        send_text("%", 1'b1);
        // direction flips mid-string with an escape pending
        set_codec(DIR_DECODE, MODE_PATH);
        send_text("%", 1'b0);
        set_codec(DIR_ENCODE, MODE_PATH);
        send_text("4", 1'b0);
        set_codec(DIR_DECODE, MODE_PATH);
        send_text("12", 1'b1);

        // every direction and mode pair, mode seven included
        for (int p = 0; p < 16; p++) begin
            dir    = p[0];
            mode   = p[3:1];
            steady = (p % 5 == 4);
            set_codec(dir, mode);
            // query encode fills the result slots fastest; stop the receiver there
            if (p == 10)
                stall_asked++;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                send_random_string(dir);
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
            end
        end
        steady = 1'b0;

        wait_drained();
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side: random ready gaps, or one long hold-off when asked
    initial begin
        int hold;
        int stalls_done;
        stalls_done = 0;
        forever begin
            if (stall_asked > stalls_done) begin
                stalls_done++;
                hold = LONG_STALL_CYCLES;
            end else begin
                hold = steady ? 0 : $urandom_range(0, 4);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
